FILE: rtl/core/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types, character codes and escape strings of the echo sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

  localparam int unsigned PosW = 5;

  // Event codes carried by req_type
  localparam logic ReqRxByte  = 1'b0;
  localparam logic ReqTxSlot  = 1'b1;

  // Character codes
  localparam logic [7:0] ChrBs  = 8'h08;
  localparam logic [7:0] ChrDel = 8'h7F;
  localparam logic [7:0] ChrR   = 8'h52;
  localparam logic [7:0] ChrCr  = 8'h0D;
  localparam logic [7:0] ChrLf  = 8'h0A;
  localparam logic [7:0] ChrA   = 8'h41;

  localparam logic [PosW-1:0] EraseLen = 5'd4;
  localparam logic [PosW-1:0] QueryLen = 5'd18;

  typedef struct packed {
    logic [7:0]      held_byte;
    logic [PosW-1:0] string_pos;
    logic            erase_pending;
    logic            query_pending;
    logic            report_wait;
    logic            tx_enable;
    logic            led_state;
  } tes_state_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_wanted;
    logic       led_level;
  } tes_result_t;

  localparam tes_state_t StateRst = '{
    held_byte:     ChrA,
    string_pos:    '0,
    erase_pending: 1'b0,
    query_pending: 1'b1,
    report_wait:   1'b0,
    tx_enable:     1'b1,
    led_state:     1'b0
  };

  // ESC [ 1 D : cursor one column left
  function automatic logic [7:0] erase_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = 8'h1B;
      2'd1:    b = 8'h5B;
      2'd2:    b = 8'h31;
      default: b = 8'h44;
    endcase
    return b;
  endfunction

  // ESC[9999C ESC[9999B ESC[6n : cursor to bottom right, ask position
  function automatic logic [7:0] query_byte(input logic [PosW-1:0] pos);
    logic [7:0] b;
    unique case (pos)
      5'd0, 5'd7, 5'd14:                     b = 8'h1B;
      5'd1, 5'd8, 5'd15:                     b = 8'h5B;
      5'd2, 5'd3, 5'd4, 5'd5,
      5'd9, 5'd10, 5'd11, 5'd12:             b = 8'h39;
      5'd6:                                  b = 8'h43;
      5'd13:                                 b = 8'h42;
      5'd16:                                 b = 8'h36;
      5'd17:                                 b = 8'h6E;
      default:                               b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tes_step.sv
// ----------------------------------------------------------------------------
// tes_step
// Next-state and result logic for one event.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_step (
  input  tes_pkg::tes_state_t  state_i,
  input  logic                 req_type_i,
  input  logic [7:0]           rx_byte_i,
  output tes_pkg::tes_state_t  state_o,
  output tes_pkg::tes_result_t result_o
);
  import tes_pkg::*;

  tes_state_t s;
  logic       sent;
  logic [7:0] byte_out;

  always_comb begin
    s        = state_i;
    sent     = 1'b0;
    byte_out = 8'h00;
    if (req_type_i == ReqRxByte) begin
      s.led_state = ~state_i.led_state;
      s.held_byte = rx_byte_i;
      if (state_i.report_wait) begin
        if (rx_byte_i == ChrR) begin
          s.report_wait = 1'b0;
          s.string_pos  = '0;
          s.tx_enable   = 1'b1;
        end
      end else begin
        if (rx_byte_i == ChrBs || rx_byte_i == ChrDel) begin
          s.erase_pending = 1'b1;
        end
        s.tx_enable = 1'b1;
      end
    end else if (state_i.tx_enable) begin
      priority if (state_i.erase_pending) begin
        if (state_i.string_pos < EraseLen) begin
          byte_out     = erase_byte(state_i.string_pos[1:0]);
          sent         = 1'b1;
          s.string_pos = state_i.string_pos + 1'b1;
        end else begin
          s.erase_pending = 1'b0;
          s.string_pos    = '0;
          s.tx_enable     = 1'b0;
        end
      end else if (state_i.query_pending) begin
        if (state_i.string_pos < QueryLen) begin
          byte_out     = query_byte(state_i.string_pos);
          sent         = 1'b1;
          s.string_pos = state_i.string_pos + 1'b1;
        end else begin
          s.query_pending = 1'b0;
          s.string_pos    = '0;
          s.tx_enable     = 1'b0;
          s.report_wait   = 1'b1;
        end
      end else begin
        byte_out = state_i.held_byte;
        sent     = 1'b1;
        // CR goes out as CR then LF
        if (state_i.held_byte == ChrCr) begin
          s.held_byte = ChrLf;
        end else begin
          s.tx_enable = 1'b0;
        end
      end
    end
  end

  assign state_o            = s;
  assign result_o.tx_valid  = sent;
  assign result_o.tx_byte   = byte_out;
  assign result_o.tx_wanted = s.tx_enable;
  assign result_o.led_level = s.led_state;

endmodule

`default_nettype wire

FILE: rtl/core/terminal_echo_sequencer.sv
// ----------------------------------------------------------------------------
// terminal_echo_sequencer
// Console echo controller between a byte receiver and a transmitter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one event per item:
//   req_type_i = 0 is a received byte (rx_byte_i), 1 is a transmitter slot.
//   Output channel (out_valid_o/out_ready_i) returns exactly one result item
//   per event: tx_valid_o/tx_byte_o (byte to send, 0 if none), tx_wanted_o
//   (slots wanted from now on) and led_level_o (activity LED).
//   Path: an accepted item waits in the input register; its result is
//   loaded into the result register and taken from there.
//   Throughput: one item per clock while out_ready_i is high. The event
//   logic is a single pass of compares and a 18-entry string lookup
//   between the two registers, and the state is updated in the same
//   cycle, so the next item sees it.
//   Stall: while the receiver holds out_ready_i low the result stays put,
//   the input register holds one more item, and in_ready_o then drops.
//   Reset: both registers empty; state starts with the position query
//   string pending, slots wanted, held byte 'A', LED off.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_echo_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       tx_wanted_o,
  output logic       led_level_o
);
  import tes_pkg::*;

  // Input register
  logic       in_valid_q;
  logic       req_q;
  logic [7:0] rx_q;

  // Event state and result register
  tes_state_t  state_q, state_d;
  tes_result_t res_q, res_d;
  logic        out_valid_q;

  logic advance;

  // The held item moves on when the result slot is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  tes_step u_step (
    .state_i   (state_q),
    .req_type_i(req_q),
    .rx_byte_i (rx_q),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateRst;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= req_type_i;
      rx_q  <= rx_byte_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_valid_o  = res_q.tx_valid;
  assign tx_byte_o   = res_q.tx_byte;
  assign tx_wanted_o = res_q.tx_wanted;
  assign led_level_o = res_q.led_level;

`ifndef ASSERT_OFF
  // Input side only blocks when a result is waiting on a stalled receiver.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("in_ready_o low without an output stall");

  // A result without a transmitted byte carries a zero byte.
  a_idle_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tx_valid_o) |-> (tx_byte_o == 8'h00))
    else $error("tx_byte_o nonzero with tx_valid_o low");

  // The report wait only follows a finished query string.
  a_wait_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.report_wait |-> !state_q.query_pending)
    else $error("report wait while query still pending");

  // String position never runs past the end of the query string.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.string_pos <= QueryLen)
    else $error("string position out of range");
`endif

endmodule

`default_nettype wire

FILE: sim/terminal_echo_checker.sv
// ----------------------------------------------------------------------------
// terminal_echo_checker
// Watches both channels of the echo sequencer, predicts each result item
// from the accepted event and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_echo_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic       req_type_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       tx_valid_i,
  input  logic [7:0] tx_byte_i,
  input  logic       tx_wanted_i,
  input  logic       led_level_i,
  output int         err_cnt_o,
  output int         pending_o,
  output int         sent_cnt_o
);

  import tes_pkg::*;

  // Escape strings, first byte in the top lane
  localparam logic [31:0]  EraseStr = {8'h1B, 8'h5B, 8'h31, 8'h44};
  localparam logic [143:0] QueryStr = {
    8'h1B, 8'h5B, 8'h39, 8'h39, 8'h39, 8'h39, 8'h43,
    8'h1B, 8'h5B, 8'h39, 8'h39, 8'h39, 8'h39, 8'h42,
    8'h1B, 8'h5B, 8'h36, 8'h6E
  };

  tes_state_t  console_st;
  tes_result_t tx_pending_q[$];
  tes_result_t got_res;
  tes_result_t want_res;
  tes_result_t next_res;

  task automatic note_failure(input string msg);
    err_cnt_o++;
    if (err_cnt_o <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // One event against the console state
  task automatic advance_console(input logic req, input logic [7:0] rx,
                                 output tes_result_t res);
    tes_result_t r;
    int          idx;
    r = '0;
    if (req == ReqRxByte) begin
      console_st.led_state = ~console_st.led_state;
      console_st.held_byte = rx;
      if (console_st.report_wait) begin
        if (rx == ChrR) begin
          console_st.report_wait = 1'b0;
          console_st.string_pos  = '0;
          console_st.tx_enable   = 1'b1;
        end
      end else begin
        if (rx == ChrBs || rx == ChrDel) console_st.erase_pending = 1'b1;
        console_st.tx_enable = 1'b1;
      end
    end else if (console_st.tx_enable) begin
      idx = int'(console_st.string_pos);
      if (console_st.erase_pending) begin
        if (console_st.string_pos < EraseLen) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = EraseStr[8*(3-idx) +: 8];
          console_st.string_pos = console_st.string_pos + 1'b1;
        end else begin
          console_st.erase_pending = 1'b0;
          console_st.string_pos    = '0;
          console_st.tx_enable     = 1'b0;
        end
      end else if (console_st.query_pending) begin
        if (console_st.string_pos < QueryLen) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = QueryStr[8*(17-idx) +: 8];
          console_st.string_pos = console_st.string_pos + 1'b1;
        end else begin
          console_st.query_pending = 1'b0;
          console_st.string_pos    = '0;
          console_st.tx_enable     = 1'b0;
          console_st.report_wait   = 1'b1;
        end
      end else begin
        // plain echo; CR goes out again as LF on the next slot
        r.tx_valid = 1'b1;
        r.tx_byte  = console_st.held_byte;
        if (console_st.held_byte == ChrCr) console_st.held_byte = ChrLf;
        else console_st.tx_enable = 1'b0;
      end
    end
    r.tx_wanted = console_st.tx_enable;
    r.led_level = console_st.led_state;
    res = r;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      console_st = StateRst;
      tx_pending_q.delete();
      err_cnt_o  = 0;
      pending_o  = 0;
      sent_cnt_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got_res = {tx_valid_i, tx_byte_i, tx_wanted_i, led_level_i};
        if (tx_pending_q.size() == 0) begin
          note_failure($sformatf("result with nothing pending: tx_valid=%0b byte=%02h",
                                 got_res.tx_valid, got_res.tx_byte));
        end else begin
          want_res = tx_pending_q.pop_front();
          if (got_res !== want_res) begin
            note_failure($sformatf(
              "exp valid=%0b byte=%02h wanted=%0b led=%0b, got %0b %02h %0b %0b",
              want_res.tx_valid, want_res.tx_byte, want_res.tx_wanted,
              want_res.led_level, got_res.tx_valid, got_res.tx_byte,
              got_res.tx_wanted, got_res.led_level));
          end
        end
        if (got_res.tx_valid === 1'b1) sent_cnt_o++;
      end
      if (in_valid_i && in_ready_i) begin
        advance_console(req_type_i, rx_byte_i, next_res);
        tx_pending_q.push_back(next_res);
      end
      pending_o = tx_pending_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_terminal_echo_sequencer.sv
// ----------------------------------------------------------------------------
// tb_terminal_echo_sequencer
// Stimulus and verdict for the echo sequencer: a directed walk through the
// position query, erase and echo cases, then random byte/slot traffic with
// idle bursts on both sides, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_terminal_echo_sequencer;

  import tes_pkg::*;

  localparam int RandItems  = 1500;
  localparam int QuietItems = 200;   // tail of the run without idling
  localparam int HoldAt     = 600;   // item count that triggers the long stall
  localparam int HoldCycles = 200;
  localparam int DrainAt    = 1000;  // item count of the drain pause

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  logic       req_type;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       tx_wanted;
  logic       led_level;

  int chk_errs;
  int chk_pending;
  int chk_sent;

  // Stimulus bookkeeping
  int n_items;
  int n_slots;
  int n_bytes;
  int n_dir;
  bit quiet;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  terminal_echo_sequencer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_type_i  (req_type),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .tx_valid_o  (tx_valid),
    .tx_byte_o   (tx_byte),
    .tx_wanted_o (tx_wanted),
    .led_level_o (led_level)
  );

  terminal_echo_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .req_type_i  (req_type),
    .rx_byte_i   (rx_byte),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .tx_valid_i  (tx_valid),
    .tx_byte_i   (tx_byte),
    .tx_wanted_i (tx_wanted),
    .led_level_i (led_level),
    .err_cnt_o   (chk_errs),
    .pending_o   (chk_pending),
    .sent_cnt_o  (chk_sent)
  );

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("** terminal_echo_sequencer: FAILED **");
    $finish;
  end

  // Receiver side: random ready bursts, one long hold-off, none in the tail
  initial begin : rx_side
    int burst;
    int hold_left;
    bit hold_done;
    burst     = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && n_items >= HoldAt) begin
        // sender keeps offering, so the block fills and drops in_ready
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 7) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Called at a falling edge, returns at a falling edge after acceptance
  task automatic send_item(input logic req, input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= req;
    rx_byte  <= b;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    n_items++;
    if (req == ReqTxSlot) n_slots++;
    else n_bytes++;
  endtask

  task automatic send_slots(input int n);
    repeat (n) send_item(ReqTxSlot, 8'($urandom_range(0, 255)));
  endtask

  // Special characters show up often, the rest is any byte
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0:       b = ChrCr;
      1:       b = ChrBs;
      2:       b = ChrDel;
      3:       b = ChrR;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  initial begin : tx_side
    int         k;
    int         guard;
    bit         drained;
    logic [7:0] b;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    req_type = ReqRxByte;
    rx_byte  = 8'h00;
    quiet    = 1'b0;
    drained  = 1'b0;
    n_items  = 0;
    n_slots  = 0;
    n_bytes  = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed walk ---
    // erase starting while the query is at position 2: tail of ESC[1D only
    send_slots(2);
    send_item(ReqRxByte, ChrBs);
    send_slots(3);
    send_slots(1);                  // slot nobody asked for
    send_item(ReqRxByte, 8'hFF);    // re-enables slots, query restarts
    send_slots(5);
    // erase starting past position 4: counts as already done
    send_item(ReqRxByte, ChrDel);
    send_slots(1);
    send_item(ReqRxByte, 8'h00);
    // whole query string plus the closing slot, into report wait
    send_slots(19);
    send_item(ReqRxByte, ChrA);     // swallowed while waiting
    send_item(ReqRxByte, ChrBs);    // no erase while waiting
    send_slots(1);
    send_item(ReqRxByte, ChrR);     // end of report, echoed
    send_slots(2);
    send_item(ReqRxByte, ChrCr);    // CR then LF
    send_slots(3);
    send_item(ReqRxByte, ChrBs);    // ESC[1D and its end slot
    send_slots(5);
    n_dir = n_items;

    // --- random traffic ---
    while (n_items < n_dir + RandItems) begin
      if (n_items >= n_dir + RandItems - QuietItems) quiet = 1'b1;
      if (!drained && n_items >= DrainAt) begin
        // let every pending result come back before going on
        drained = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk_i);
        while (chk_pending != 0) @(negedge clk_i);
      end
      if ($urandom_range(0, 3) != 0) begin
        // byte followed by the slots it needs, sometimes too many or too few
        b = pick_byte();
        send_item(ReqRxByte, b);
        if (b == ChrCr) k = 2;
        else if (b == ChrBs || b == ChrDel) k = 5;
        else k = 1;
        if ($urandom_range(0, 3) == 0) k = k + $urandom_range(0, 2);
        else if ($urandom_range(0, 5) == 0) k = $urandom_range(0, k - 1);
        send_slots(k);
      end else begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end

    // --- drain and verdict ---
    in_valid <= 1'b0;
    guard = 0;
    while (chk_pending != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (10) @(negedge clk_i);

    $display("Covered %0d events (%0d bytes, %0d slots), %0d bytes sent back:",
             n_items, n_bytes, n_slots, chk_sent);
    $display("  position query, erase mid-query, report wait, CR/LF, erase, stalls");
    if (chk_errs == 0 && chk_pending == 0) begin
      $display("** terminal_echo_sequencer: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", chk_errs, chk_pending);
      $display("** terminal_echo_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/tes_pkg.sv
rtl/core/tes_step.sv
rtl/core/terminal_echo_sequencer.sv
sim/terminal_echo_checker.sv
sim/tb_terminal_echo_sequencer.sv
